FILE: hdl/spt_pkg.sv
// shared types and constants for the sorted point table
// no dependencies; every file but spt_fifo imports this package
package spt_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int CMD_DEPTH        = 2;
    localparam int RES_DEPTH        = 2;
    localparam int COORD_W          = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_LISTED   = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic {
        BK_CMD  = 1'b0,
        BK_DUMP = 1'b1
    } t_back_state;

    typedef struct packed {
        logic ins;
        logic del;
        logic dump;
        logic clr;
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [COORD_W-1:0]  key_x;
        logic signed [COORD_W-1:0]  value_y;
    } t_cmd;

    typedef struct packed {
        t_status                    status;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic                       last;
    } t_result;

    typedef struct packed {
        logic ins;
        logic del;
        logic clr;
    } t_cell_ctl;

    typedef struct packed {
        logic found;
        logic full;
        logic none;
        logic rd_last;
    } t_cell_stat;

endpackage

FILE: hdl/sorted_point_table.sv
// top level of the sorted point table: front queue, sequencer and result queue
// depends on spt_pkg, spt_front, spt_back and spt_fifo
//
// Keeps up to CAPACITY (x, y) points sorted by signed x with unique keys.
// Items enter a two-entry command queue; the sequencer then takes one item
// per cycle for insert, delete and clear, because every cell of the table
// compares its key with the request and shifts in the same cycle. A dump
// occupies the sequencer until every entry is listed, one listed entry per cycle
// through the single table read port. Results leave through a two-entry
// queue, so the sequencer stalls only when that queue is full. No clearing
// pass follows reset: the entry count alone marks which cells hold points.
module sorted_point_table #(
    parameter int CAPACITY = spt_pkg::CAPACITY_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_opcode,
    input  logic signed [spt_pkg::COORD_W-1:0] i_key_x,
    input  logic signed [spt_pkg::COORD_W-1:0] i_value_y,
    input  logic                               pop,
    output logic                               empty,
    output logic [2:0]                         o_status,
    output logic signed [spt_pkg::COORD_W-1:0] o_out_x,
    output logic signed [spt_pkg::COORD_W-1:0] o_out_y,
    output logic                               o_last
);
    import spt_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_empty, w_cmd_pop;
    logic    w_res_full, w_res_push;
    t_result w_res_in, w_res_out;

    spt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_key_x     (i_key_x),
        .i_value_y   (i_value_y),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_empty (w_cmd_empty),
        .o_cmd       (w_cmd)
    );

    spt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    spt_fifo #(
        .T     (t_result),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign o_status = w_res_out.status;
    assign o_out_x  = w_res_out.x;
    assign o_out_y  = w_res_out.y;
    assign o_last   = w_res_out.last;

endmodule

FILE: hdl/spt_fifo.sv
// small first-in first-out queue of any packed type
// uses nothing outside this file
module spt_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;
    logic            w_do_push, w_do_pop;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/spt_front.sv
// front end: accepts input items, decodes the opcode and queues commands
// depends on spt_pkg and spt_fifo
module spt_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_opcode,
    input  logic signed [spt_pkg::COORD_W-1:0] i_key_x,
    input  logic signed [spt_pkg::COORD_W-1:0] i_value_y,
    input  logic                               i_cmd_pop,
    output logic                               o_cmd_empty,
    output spt_pkg::t_cmd                      o_cmd
);
    import spt_pkg::*;

    t_cmd w_cmd;

    always_comb begin
        w_cmd         = '0;
        w_cmd.key_x   = i_key_x;
        w_cmd.value_y = i_value_y;
        case (t_opcode'(i_opcode))
            OP_INSERT: w_cmd.kind.ins  = 1'b1;
            OP_DELETE: w_cmd.kind.del  = 1'b1;
            OP_DUMP:   w_cmd.kind.dump = 1'b1;
            OP_CLEAR:  w_cmd.kind.clr  = 1'b1;
            default:   w_cmd.kind.clr  = 1'b1;
        endcase
    end

    spt_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_empty (o_cmd_empty),
        .o_data  (o_cmd)
    );

endmodule

FILE: hdl/spt_cells.sv
// row of sorted table cells; each compares its key with the request and shifts
// depends on spt_pkg
module spt_cells #(
    parameter int CAPACITY = spt_pkg::CAPACITY_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spt_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [spt_pkg::COORD_W-1:0]   i_key_x,
    input  logic signed [spt_pkg::COORD_W-1:0]   i_value_y,
    input  logic [$clog2(CAPACITY)-1:0]          i_rd_idx,
    output logic signed [spt_pkg::COORD_W-1:0]   o_rd_key,
    output logic signed [spt_pkg::COORD_W-1:0]   o_rd_val,
    output spt_pkg::t_cell_stat                  o_stat
);
    import spt_pkg::*;

    localparam int CNTW = $clog2(CAPACITY + 1);

    logic signed [COORD_W-1:0] r_key [CAPACITY];
    logic signed [COORD_W-1:0] r_val [CAPACITY];
    logic [CNTW-1:0]           r_count, n_count;

    logic [CAPACITY-1:0] w_valid, w_eq, w_gt, w_ge_pos, w_at_del, w_first;
    logic signed [COORD_W-1:0] w_prev_key [CAPACITY];
    logic signed [COORD_W-1:0] w_prev_val [CAPACITY];
    logic signed [COORD_W-1:0] w_next_key [CAPACITY];
    logic signed [COORD_W-1:0] w_next_val [CAPACITY];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i]  = (CNTW'(i) < r_count);
            w_eq[i]     = (r_key[i] == i_key_x);
            w_gt[i]     = (r_key[i] > i_key_x);
            w_ge_pos[i] = !w_valid[i] || w_gt[i];
            w_at_del[i] = w_valid[i] && (w_gt[i] || w_eq[i]);
        end
    end

    assign o_stat.found   = |(w_valid & w_eq);
    assign o_stat.full    = (r_count == CNTW'(CAPACITY));
    assign o_stat.none    = (r_count == '0);
    assign o_stat.rd_last = ((CNTW'(i_rd_idx) + CNTW'(1)) == r_count);
    assign o_rd_key       = r_key[i_rd_idx];
    assign o_rd_val       = r_val[i_rd_idx];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_first[g]    = 1'b1;
                assign w_prev_key[g] = i_key_x;
                assign w_prev_val[g] = i_value_y;
            end else begin : g_body
                assign w_first[g]    = !w_ge_pos[g-1];
                assign w_prev_key[g] = r_key[g-1];
                assign w_prev_val[g] = r_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next_key[g] = r_key[g];
                assign w_next_val[g] = r_val[g];
            end else begin : g_inner
                assign w_next_key[g] = r_key[g+1];
                assign w_next_val[g] = r_val[g+1];
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.ins && w_ge_pos[g]) begin
                    r_key[g] <= w_first[g] ? i_key_x   : w_prev_key[g];
                    r_val[g] <= w_first[g] ? i_value_y : w_prev_val[g];
                end else if (i_ctl.del && w_at_del[g]) begin
                    r_key[g] <= w_next_key[g];
                    r_val[g] <= w_next_val[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_ctl.clr) begin
            n_count = '0;
        end else if (i_ctl.ins) begin
            n_count = r_count + CNTW'(1);
        end else if (i_ctl.del) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/spt_back.sv
// back end: sequencer that carries out queued commands on the cell row
// depends on spt_pkg and spt_cells
module spt_back #(
    parameter int CAPACITY = spt_pkg::CAPACITY_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  spt_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output spt_pkg::t_result o_res
);
    import spt_pkg::*;

    localparam int IDXW = $clog2(CAPACITY);

    t_back_state               r_state, n_state;
    logic [IDXW-1:0]           r_idx, n_idx;
    logic [IDXW-1:0]           w_rd_idx;
    t_cell_ctl                 w_ctl;
    t_cell_stat                w_stat;
    logic signed [COORD_W-1:0] w_rd_key, w_rd_val;

    spt_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_key_x   (i_cmd.key_x),
        .i_value_y (i_cmd.value_y),
        .i_rd_idx  (w_rd_idx),
        .o_rd_key  (w_rd_key),
        .o_rd_val  (w_rd_val),
        .o_stat    (w_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        w_ctl      = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        w_rd_idx   = '0;
        case (r_state)
            BK_CMD: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop  = 1'b1;
                    o_res_push = 1'b1;
                    if (i_cmd.kind.ins) begin
                        if (w_stat.found) begin
                            o_res.status = ST_DUP;
                        end else if (w_stat.full) begin
                            o_res.status = ST_FULL;
                        end else begin
                            w_ctl.ins    = 1'b1;
                            o_res.status = ST_DONE;
                        end
                    end else if (i_cmd.kind.del) begin
                        if (w_stat.found) begin
                            w_ctl.del    = 1'b1;
                            o_res.status = ST_DONE;
                        end else begin
                            o_res.status = ST_NOTFOUND;
                        end
                    end else if (i_cmd.kind.dump) begin
                        if (w_stat.none) begin
                            o_res.status = ST_EMPTY;
                        end else begin
                            o_res.status = ST_LISTED;
                            o_res.x      = w_rd_key;
                            o_res.y      = w_rd_val;
                            o_res.last   = w_stat.rd_last;
                            if (!w_stat.rd_last) begin
                                n_state = BK_DUMP;
                                n_idx   = IDXW'(1);
                            end
                        end
                    end else begin
                        w_ctl.clr    = 1'b1;
                        o_res.status = ST_DONE;
                    end
                end
            end
            BK_DUMP: begin
                w_rd_idx = r_idx;
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.status = ST_LISTED;
                    o_res.x      = w_rd_key;
                    o_res.y      = w_rd_val;
                    o_res.last   = w_stat.rd_last;
                    if (w_stat.rd_last) begin
                        n_state = BK_CMD;
                    end else begin
                        n_idx = r_idx + IDXW'(1);
                    end
                end
            end
            default: begin
                n_state = BK_CMD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CMD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the sorted point table: a directed script, then random traffic
// depends on spt_pkg and sorted_point_table; a built-in model predicts each result the script does not fix
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spt_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEFAULT;
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 250;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_status            status;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } point_result_t;

    typedef struct {
        t_opcode     op;
        logic [31:0] kx;
        logic [31:0] vy;
        bit          typed;
        t_status     status;
    } script_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [1:0]          i_opcode = '0;
    logic signed [31:0]  i_key_x = '0;
    logic signed [31:0]  i_value_y = '0;
    logic                pop = 1'b0;
    logic                empty;
    logic [2:0]          o_status;
    logic signed [31:0]  o_out_x;
    logic signed [31:0]  o_out_y;
    logic                o_last;

    logic signed [31:0]  model_keys [CAPACITY];
    logic signed [31:0]  model_ys [CAPACITY];
    int                  model_count = 0;
    point_result_t       pending_results[$];
    int                  mismatch_count = 0;
    int                  requests_sent = 0;
    int                  burst_left = 1;
    logic [15:0]         pop_pattern = 16'hFFFF;
    logic [7:0]          pattern_age = '0;
    int                  idle_cycles = 0;

    script_row_t warmup_script [23] = '{
        '{OP_DUMP,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOTFOUND},
        '{OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, ST_DONE},
        '{OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, ST_DONE},
        '{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_DONE},
        '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, ST_DUP},
        '{OP_INSERT, 32'h8000_0000, 32'h0000_0001, 1'b1, ST_DUP},
        '{OP_INSERT, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0, ST_DONE},
        '{OP_INSERT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, ST_DONE},
        '{OP_INSERT, 32'h7FFF_FFFE, 32'h5555_5555, 1'b0, ST_DONE},
        '{OP_DUMP,   32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE},
        '{OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DELETE, 32'h1234_5678, 32'h0000_0000, 1'b1, ST_NOTFOUND},
        '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DUMP,   32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE},
        '{OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DUMP,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_DELETE, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_NOTFOUND},
        '{OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_INSERT, 32'h0001_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DUMP,   32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE}
    };

    sorted_point_table #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_opcode  (i_opcode),
        .i_key_x   (i_key_x),
        .i_value_y (i_value_y),
        .pop       (pop),
        .empty     (empty),
        .o_status  (o_status),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_last    (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic point_result_t make_result(t_status st, logic signed [31:0] x,
                                                  logic signed [31:0] y, logic lst);
        point_result_t r;
        r.status = st;
        r.x      = x;
        r.y      = y;
        r.last   = lst;
        return r;
    endfunction

    function automatic void predict_table_response(input t_opcode op,
                                                   input logic signed [31:0] kx,
                                                   input logic signed [31:0] vy,
                                                   output point_result_t replies[$]);
        int hit;
        int slot;
        replies = {};
        hit = -1;
        for (int i = 0; i < model_count; i++) begin
            if (model_keys[i] === kx) begin
                hit = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (hit >= 0) begin
                    replies.push_back(make_result(ST_DUP, 0, 0, 1'b1));
                end else if (model_count >= CAPACITY) begin
                    replies.push_back(make_result(ST_FULL, 0, 0, 1'b1));
                end else begin
                    slot = 0;
                    for (int i = 0; i < model_count; i++) begin
                        if (model_keys[i] < kx) begin
                            slot = i + 1;
                        end
                    end
                    for (int i = model_count; i > slot; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_ys[i]   = model_ys[i-1];
                    end
                    model_keys[slot] = kx;
                    model_ys[slot]   = vy;
                    model_count++;
                    replies.push_back(make_result(ST_DONE, 0, 0, 1'b1));
                end
            end
            OP_DELETE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < model_count; i++) begin
                        model_keys[i] = model_keys[i+1];
                        model_ys[i]   = model_ys[i+1];
                    end
                    model_count--;
                    replies.push_back(make_result(ST_DONE, 0, 0, 1'b1));
                end else begin
                    replies.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
                end
            end
            OP_DUMP: begin
                if (model_count == 0) begin
                    replies.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                end else begin
                    for (int i = 0; i < model_count; i++) begin
                        replies.push_back(make_result(ST_LISTED, model_keys[i], model_ys[i],
                                                      i + 1 == model_count));
                    end
                end
            end
            default: begin
                model_count = 0;
                replies.push_back(make_result(ST_DONE, 0, 0, 1'b1));
            end
        endcase
    endfunction

    function automatic logic signed [31:0] pick_point_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && model_count > 0) begin
            return model_keys[$urandom_range(0, model_count - 1)];
        end
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel == 5) begin
            return ($urandom_range(0, 15) - 8) << 16;
        end
        return $urandom;
    endfunction

    // called at a rising edge; returns at the edge that accepted the request, or later after a random idle gap
    task automatic send_request(input t_opcode op, input logic [31:0] kx, input logic [31:0] vy,
                                input bit typed, input t_status typed_status);
        point_result_t replies[$];
        int gap;
        push      <= 1'b1;
        i_opcode  <= op;
        i_key_x   <= kx;
        i_value_y <= vy;
        do @(posedge i_clk); while (full !== 1'b0);
        requests_sent++;
        predict_table_response(op, kx, vy, replies);
        if (typed) begin
            pending_results.push_back(make_result(typed_status, 0, 0, 1'b1));
        end else begin
            foreach (replies[i]) pending_results.push_back(replies[i]);
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                push      <= 1'b0;
                i_opcode  <= 2'($urandom);
                i_key_x   <= $urandom;
                i_value_y <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int episode;
        int steps;
        int unsigned pick;
        t_opcode op;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (warmup_script[i]) begin
            send_request(warmup_script[i].op, warmup_script[i].kx, warmup_script[i].vy,
                         warmup_script[i].typed, warmup_script[i].status);
        end

        episode = 0;
        while (requests_sent < $size(warmup_script) + RANDOM_ITEMS) begin
            if (episode == 0 || $urandom_range(0, 5) == 0) begin
                // fill to capacity, push against the full table, then dump, delete, insert and sometimes clear
                while (model_count < CAPACITY) begin
                    send_request(OP_INSERT, $urandom, $urandom, 1'b0, ST_DONE);
                end
                send_request(OP_INSERT, $urandom, $urandom, 1'b0, ST_DONE);
                send_request(OP_INSERT, model_keys[$urandom_range(0, CAPACITY - 1)],
                             $urandom, 1'b0, ST_DONE);
                send_request(OP_DUMP, $urandom, $urandom, 1'b0, ST_DONE);
                send_request(OP_DELETE, model_keys[$urandom_range(0, CAPACITY - 1)],
                             $urandom, 1'b0, ST_DONE);
                send_request(OP_INSERT, pick_point_key(), $urandom, 1'b0, ST_DONE);
                if ($urandom_range(0, 1) == 0) begin
                    send_request(OP_CLEAR, $urandom, $urandom, 1'b0, ST_DONE);
                end
            end else begin
                steps = $urandom_range(8, 24);
                repeat (steps) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) op = OP_INSERT;
                    else if (pick < 78) op = OP_DELETE;
                    else if (pick < 94) op = OP_DUMP;
                    else op = OP_CLEAR;
                    send_request(op, pick_point_key(), $urandom, 1'b0, ST_DONE);
                end
            end
            episode++;
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin : result_drain
        point_result_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d x %h y %h last %b",
                           o_status, o_out_x, o_out_y, o_last);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("o_status: expected %0d, got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_out_x !== want.x) begin
                        $error("o_out_x: expected %h, got %h", want.x, o_out_x);
                        mismatch_count++;
                    end
                    if (o_out_y !== want.y) begin
                        $error("o_out_y: expected %h, got %h", want.y, o_out_y);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("o_last: expected %b, got %b", want.last, o_last);
                        mismatch_count++;
                    end
                end
            end
            pattern_age <= pattern_age + 8'd1;
            if (pattern_age == 8'd0) begin
                pop_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                           : (16'($urandom) | 16'h0101);
            end else begin
                pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
            end
            pop <= pop_pattern[0];
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
